[hw/rtl/ppubg_pkg.sv]
// Shared types and constants for the picture unit register port and background pixel unit.
// Used by the controller, the datapath, the top level and the checker; depends on nothing.
package ppubg_pkg;

    localparam int MEM_ADDR_BITS = 14;

    localparam logic [15:0] PATTERN_BASE = 16'h1000;
    localparam logic [15:0] NAME_BASE    = 16'h2000;
    localparam logic [15:0] ATTR_BASE    = 16'h23C0;
    localparam logic [15:0] PALETTE_BASE = 16'h3F00;
    localparam logic [15:0] ROW_STEP     = 16'd32;
    localparam logic [15:0] COL_STEP     = 16'd1;

    localparam logic [1:0] OP_REG_WRITE = 2'd0;
    localparam logic [1:0] OP_REG_READ  = 2'd1;
    localparam logic [1:0] OP_RENDER    = 2'd2;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    // Status bits 6 and 5 survive a status read.
    localparam logic [7:0] STATUS_KEEP_MASK = 8'h60;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] color_byte;
    } t_out_word;

    typedef enum logic [2:0] {
        ADDR_NAME,
        ADDR_ATTR,
        ADDR_PLANE0,
        ADDR_PLANE1,
        ADDR_PALETTE
    } t_addr_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_NAME,
        S_ATTR,
        S_PLANE0,
        S_PLANE1,
        S_PALETTE,
        S_PIXEL
    } t_state;

    typedef struct packed {
        logic      load_item;
        logic      mem_rd;
        t_addr_sel addr_sel;
        logic      latch_tile;
        logic      latch_attr;
        logic      latch_plane0;
        logic      reg_done;
        logic      pix_done;
    } t_dp_cmd;

    typedef struct packed {
        logic in_is_render;
        logic out_free;
    } t_dp_status;

endpackage

[hw/rtl/ppubg_dp.sv]
// Datapath: item register, register file, video address, video memory, render address
// unit and output register. Depends on ppubg_pkg; driven by ppubg_ctrl.
module ppubg_dp
    import ppubg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_word    i_in_word,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_out_stall,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic        o_out_valid,
    output t_out_word   o_out_word
);

    logic [7:0]  r_vram [2**MEM_ADDR_BITS];
    logic [7:0]  r_rdata;

    t_in_word    r_item;
    logic [1:0]  r_nt_sel;
    logic [7:0]  r_regs [8];
    logic [7:0]  n_regs [8];
    logic [15:0] r_vaddr;
    logic [15:0] n_vaddr;
    logic        r_low_next;
    logic        n_low_next;

    logic [7:0]  r_tile;
    logic [1:0]  r_pal;
    logic [7:0]  r_plane0;

    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;

    logic [4:0]  col;
    logic [4:0]  row;
    logic [1:0]  quad;
    logic [2:0]  pix_bit;
    logic [1:0]  cidx;
    logic [15:0] table_offs;
    logic [15:0] rd_addr;
    logic        mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [7:0]  reg_rd;
    logic        is_write;

    assign col        = r_item.pixel_x[7:3];
    assign row        = r_item.pixel_y[7:3];
    assign quad       = {row[1], col[1]};
    assign pix_bit    = ~r_item.pixel_x[2:0];
    // In the palette state the registered read data is the second bit plane.
    assign cidx       = {r_rdata[pix_bit], r_plane0[pix_bit]};
    assign table_offs = {4'b0, r_nt_sel, 10'b0};

    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_NAME:    rd_addr = NAME_BASE + table_offs + {6'b0, row, col};
            ADDR_ATTR:    rd_addr = ATTR_BASE + table_offs + {10'b0, row[4:2], col[4:2]};
            ADDR_PLANE0:  rd_addr = PATTERN_BASE + {4'b0, r_tile, 1'b0, r_item.pixel_y[2:0]};
            ADDR_PLANE1:  rd_addr = PATTERN_BASE + {4'b0, r_tile, 1'b1, r_item.pixel_y[2:0]};
            ADDR_PALETTE: rd_addr = PALETTE_BASE + {12'b0, r_pal, cidx};
            default:      rd_addr = NAME_BASE;
        endcase
    end

    assign is_write = (r_item.opcode == OP_REG_WRITE);
    assign mem_we   = i_cmd.reg_done && is_write && (r_item.reg_index == REG_DATA);
    assign mem_addr = mem_we ? r_vaddr[MEM_ADDR_BITS-1:0] : rd_addr[MEM_ADDR_BITS-1:0];
    assign reg_rd   = r_regs[r_item.reg_index];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vram[mem_addr] <= r_item.write_data;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_vram[mem_addr];
        end
    end

    // Register side effects are applied once, when the result word is loaded.
    always_comb begin
        n_regs     = r_regs;
        n_vaddr    = r_vaddr;
        n_low_next = r_low_next;
        if (i_cmd.reg_done) begin
            if (is_write) begin
                n_regs[r_item.reg_index] = r_item.write_data;
                if (r_item.reg_index == REG_ADDRESS) begin
                    n_vaddr    = r_low_next ? (r_vaddr | {8'b0, r_item.write_data})
                                            : {r_item.write_data, 8'b0};
                    n_low_next = ~r_low_next;
                end else if (r_item.reg_index == REG_DATA) begin
                    n_vaddr = r_vaddr + (r_regs[REG_CONTROL][2] ? ROW_STEP : COL_STEP);
                end
            end else if (r_item.opcode == OP_REG_READ && r_item.reg_index == REG_STATUS) begin
                n_regs[REG_STATUS] = reg_rd & STATUS_KEEP_MASK;
            end
        end
    end

    always_comb begin
        n_out_word = '0;
        if (i_cmd.reg_done && r_item.opcode == OP_REG_READ) begin
            n_out_word.read_data = reg_rd;
        end
        if (i_cmd.pix_done) begin
            n_out_word.color_byte = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs      <= '{default: 8'h00};
            r_vaddr     <= '0;
            r_low_next  <= 1'b0;
            r_nt_sel    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_regs     <= n_regs;
            r_vaddr    <= n_vaddr;
            r_low_next <= n_low_next;
            if (i_cfg_wr_en) begin
                r_nt_sel <= i_cfg_wr_data;
            end
            if (i_cmd.reg_done || i_cmd.pix_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_word;
        end
        if (i_cmd.latch_tile) begin
            r_tile <= r_rdata;
        end
        if (i_cmd.latch_attr) begin
            r_pal <= r_rdata[{quad, 1'b0} +: 2];
        end
        if (i_cmd.latch_plane0) begin
            r_plane0 <= r_rdata;
        end
        if (i_cmd.reg_done || i_cmd.pix_done) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_status.in_is_render = (i_in_word.opcode == OP_RENDER);
    assign o_status.out_free     = !r_out_valid || !i_out_stall;
    assign o_out_valid           = r_out_valid;
    assign o_out_word            = r_out_word;

endmodule

[hw/rtl/ppubg_ctrl.sv]
// Controller state machine: sequences register operations and the five dependent
// memory reads of a render. Depends on ppubg_pkg; drives ppubg_dp.
module ppubg_ctrl
    import ppubg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = i_status.in_is_render ? S_NAME : S_REG;
                end
            end
            S_REG: begin
                if (i_status.out_free) begin
                    o_cmd.reg_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_NAME: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = ADDR_NAME;
                n_state = S_ATTR;
            end
            S_ATTR: begin
                o_cmd.mem_rd     = 1'b1;
                o_cmd.addr_sel   = ADDR_ATTR;
                o_cmd.latch_tile = 1'b1;
                n_state = S_PLANE0;
            end
            S_PLANE0: begin
                o_cmd.mem_rd     = 1'b1;
                o_cmd.addr_sel   = ADDR_PLANE0;
                o_cmd.latch_attr = 1'b1;
                n_state = S_PLANE1;
            end
            S_PLANE1: begin
                o_cmd.mem_rd       = 1'b1;
                o_cmd.addr_sel     = ADDR_PLANE1;
                o_cmd.latch_plane0 = 1'b1;
                n_state = S_PALETTE;
            end
            S_PALETTE: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = ADDR_PALETTE;
                n_state = S_PIXEL;
            end
            S_PIXEL: begin
                // The palette byte stays in the read register until the word is loaded.
                if (i_status.out_free) begin
                    o_cmd.pix_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/ppu_register_port_and_background_pixel_unit.sv]
// Usage
// Input channel: i_in_valid, i_in_word, o_in_stall. A word is taken at a rising edge
// with i_in_valid high and o_in_stall low. Output channel: o_out_valid, o_out_word,
// i_out_stall; one result word leaves for every input word, in order.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the name table select at the
// edge; write it only while the unit is idle.
// Sequencing: a register write or read passes through the register state, which loads
// its result into the output register once that is free, then returns to idle. A render
// performs five dependent reads of the single-port video memory (name entry, attribute,
// two pattern planes, palette byte), one per cycle, and then outputs the palette byte.
// Reset (synchronous, active low) clears the registers, the video address, the byte
// latch, the name table select and the output valid; video memory is not cleared and
// must be written before it is read.
// A stalled result word holds in the output register; the next input word is still
// taken, and the controller holds its result state until the output register frees.
// Depends on ppubg_pkg, ppubg_ctrl and ppubg_dp.
module ppu_register_port_and_background_pixel_unit
    import ppubg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_word   i_in_word,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  logic       i_out_stall,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ppubg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ppubg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_word     (i_in_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word)
    );

endmodule

[hw/rtl/ppubg_checker.sv]
// Port-level checker for the picture unit top level, attached by a bind statement.
// Depends on ppubg_pkg.
module ppubg_checker
    import ppubg_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input t_out_word  o_out_word,
    input logic       i_out_stall
);

    // After reset the unit is empty and ready for a word.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("unit not idle after reset");

    // An accepted word keeps the unit busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again straight after acceptance");

    // A new result only appears straight after the unit was busy processing a word.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word appeared without work in progress");

    // A word carries either a register byte or a colour byte, never both.
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.read_data == 8'h00 || o_out_word.color_byte == 8'h00))
        else $error("result word carries both a register and a colour byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result word dropped");

endmodule

bind ppu_register_port_and_background_pixel_unit ppubg_checker u_checker (.*);
